### rtl/cbts_pkg.sv
// Shared types, widths and constants for the CAN bit timing search block.
package cbts_pkg;

    localparam int W_CLK  = 27;
    localparam int W_RATE = 20;
    localparam int W_PSC  = 10;
    localparam int W_SEG  = 4;
    localparam int W_Q    = 5;
    localparam int W_WORD = 32;
    localparam int W_CNT  = 5;
    localparam int W_ADDR = 3;

    localparam logic [W_CNT-1:0]  DIV_STEPS     = 5'd27;
    localparam logic [W_PSC-1:0]  MAX_PRESCALER = 10'd1023;
    localparam logic [W_CLK-1:0]  MIN_QUANTA    = 27'd5;
    localparam logic [W_CLK-1:0]  MAX_QUANTA    = 27'd16;
    localparam logic [W_CLK-1:0]  CLOCK_RESET   = 27'd36000000;
    localparam logic [W_WORD-1:0] BRP_MASK      = 32'h0000_03ff;
    localparam logic [W_WORD-1:0] SEG_MASK      = 32'h007f_0000;
    localparam int                SEG1_SHIFT    = 16;
    localparam int                SEG2_SHIFT    = 20;

    localparam logic [W_ADDR-1:0] REG_CLOCK     = 3'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic             start;
        logic [W_CLK-1:0] dividend;
        logic [W_CLK-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [W_CLK-1:0] quotient;
        logic [W_CLK-1:0] remainder;
    } t_div_rsp;

endpackage

### rtl/cbts_div.sv
// Shared restoring divider, one quotient bit per cycle.
module cbts_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbts_pkg::t_div_req i_req,
    output cbts_pkg::t_div_rsp o_rsp
);
    import cbts_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [W_CNT-1:0] r_cnt;
    logic [W_CLK-1:0] r_rem;
    logic [W_CLK-1:0] r_quo;
    logic [W_CLK-1:0] r_dvs;

    logic [W_CLK:0]   w_shift;
    logic [W_CLK:0]   w_diff;

    assign w_shift = {r_rem, r_quo[W_CLK-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            // keep the trial difference when it did not go negative
            if (!w_diff[W_CLK]) begin
                r_rem <= w_diff[W_CLK-1:0];
                r_quo <= {r_quo[W_CLK-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[W_CLK-1:0];
                r_quo <= {r_quo[W_CLK-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

### rtl/can_bit_timing_search_core.sv
// CAN bit timing search top level: sequencer, config port and result register.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) carries one word: the requested
//    bit rate and the apply flag. A word is taken when valid is high and
//    stall is low; stall stays high while a search runs.
//  - Output channel (o_out_valid / i_out_stall) returns one result word per
//    input word, held in an output register until the receiver takes it.
//  - The APB port holds the peripheral clock in hertz at address 0; write it
//    only while no search is in flight. pready is always high.
//  - Each prescaler tried costs two passes through the shared 27-step
//    divider (clock / P, then that / rate). The search walks P = 1 upward
//    and stops on the first hit, or at P = 1023 when nothing fits. A zero
//    rate skips the divider and goes straight to the failed result.
//  - The result stays in the output register while i_out_stall is high; a
//    new search may start meanwhile and waits at its end for the register.
//  - Reset (synchronous, active low) loads the clock register with 36 MHz,
//    clears the timing word and drops the output valid.
module can_bit_timing_search_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cbts_pkg::W_RATE-1:0]  i_requested_rate,
    input  logic                         i_apply_setting,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic [cbts_pkg::W_RATE-1:0]  o_achieved_rate,
    output logic [cbts_pkg::W_PSC-1:0]   o_prescaler,
    output logic [cbts_pkg::W_SEG-1:0]   o_segment_one,
    output logic [cbts_pkg::W_SEG-1:0]   o_segment_two,
    output logic [cbts_pkg::W_WORD-1:0]  o_timing_word,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cbts_pkg::W_ADDR-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import cbts_pkg::*;

    t_state r_state, n_state;

    logic [W_CLK-1:0]  r_clock;
    logic [W_WORD-1:0] r_timing;
    logic [W_RATE-1:0] r_rate;
    logic              r_apply;
    logic [W_PSC-1:0]  r_psc;
    logic [W_Q-1:0]    r_quanta;
    logic              r_ok;

    logic              r_out_valid;
    logic              r_out_found;
    logic [W_RATE-1:0] r_out_rate;
    logic [W_PSC-1:0]  r_out_psc;
    logic [W_SEG-1:0]  r_out_seg1;
    logic [W_SEG-1:0]  r_out_seg2;
    logic [W_WORD-1:0] r_out_word;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic              w_accept;
    logic              w_hit;
    logic              w_last;
    logic              w_out_free;
    logic              w_load;
    logic [W_PSC-1:0]  w_psc_inc;
    logic [W_SEG-1:0]  w_seg1;
    logic [W_SEG-1:0]  w_seg2;
    logic [W_WORD-1:0] w_word_new;

    cbts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[W_ADDR-1] == REG_CLOCK[W_ADDR-1])
                  ? {{(32-W_CLK){1'b0}}, r_clock} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= CLOCK_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[W_ADDR-1] == REG_CLOCK[W_ADDR-1]) begin
            r_clock <= pwdata[W_CLK-1:0];
        end
    end

    // ---------------- search checks ----------------
    assign w_accept   = i_in_valid && !o_in_stall;
    // quotient of the second pass is Q; (clk/P)/Q == rate exactly when the
    // remainder of (clk/P)/rate is below Q
    assign w_hit      = (w_rsp.quotient >= MIN_QUANTA) && (w_rsp.quotient <= MAX_QUANTA)
                      && (w_rsp.remainder < w_rsp.quotient);
    assign w_last     = (r_psc == MAX_PRESCALER);
    assign w_psc_inc  = r_psc + 1'b1;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // segment split: seg2 = (Q-1)/2 never reaches the cap of 8 for Q <= 16
    assign w_seg2 = W_SEG'((r_quanta - 1'b1) >> 1);
    assign w_seg1 = W_SEG'(r_quanta - 1'b1) - w_seg2;

    assign w_word_new = (r_timing & ~(BRP_MASK | SEG_MASK))
                      | {{(W_WORD-W_PSC){1'b0}}, r_psc - 1'b1}
                      | ({{(W_WORD-W_SEG){1'b0}}, w_seg1 - 1'b1} << SEG1_SHIFT)
                      | ({{(W_WORD-3){1'b0}}, w_seg2[2:0] - 3'd1} << SEG2_SHIFT);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_requested_rate == '0) ? S_FINISH : S_DIV1;
                end
            end
            S_DIV1: begin
                if (w_rsp.done) n_state = S_DIV2;
            end
            S_DIV2: begin
                if (w_rsp.done) begin
                    n_state = (w_hit || w_last) ? S_FINISH : S_DIV1;
                end
            end
            S_FINISH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = r_clock;
        w_req.divisor  = {{(W_CLK-W_PSC){1'b0}}, w_psc_inc};
        w_load         = 1'b0;
        o_in_stall     = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall     = 1'b0;
                w_req.start    = w_accept && (i_requested_rate != '0);
                w_req.dividend = r_clock;
                w_req.divisor  = {{(W_CLK-1){1'b0}}, 1'b1};
            end
            S_DIV1: begin
                w_req.start    = w_rsp.done;
                w_req.dividend = w_rsp.quotient;
                w_req.divisor  = {{(W_CLK-W_RATE){1'b0}}, r_rate};
            end
            S_DIV2: begin
                w_req.start    = w_rsp.done && !w_hit && !w_last;
                w_req.dividend = r_clock;
                w_req.divisor  = {{(W_CLK-W_PSC){1'b0}}, w_psc_inc};
            end
            S_FINISH: begin
                w_load = w_out_free;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timing    <= '0;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) r_ok <= 1'b0;
            if (r_state == S_DIV2 && w_rsp.done && w_hit) r_ok <= 1'b1;
            if (w_load && r_ok && r_apply) r_timing <= w_word_new;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- search datapath ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rate  <= i_requested_rate;
            r_apply <= i_apply_setting;
            r_psc   <= {{(W_PSC-1){1'b0}}, 1'b1};
        end
        if (r_state == S_DIV2 && w_rsp.done) begin
            r_quanta <= w_rsp.quotient[W_Q-1:0];
            if (!w_hit && !w_last) r_psc <= w_psc_inc;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_found <= r_ok;
            r_out_rate  <= r_ok ? r_rate : '0;
            r_out_psc   <= r_ok ? r_psc : '0;
            r_out_seg1  <= r_ok ? w_seg1 : '0;
            r_out_seg2  <= r_ok ? w_seg2 : '0;
            r_out_word  <= (r_ok && r_apply) ? w_word_new : r_timing;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out_found;
    assign o_achieved_rate = r_out_rate;
    assign o_prescaler     = r_out_psc;
    assign o_segment_one   = r_out_seg1;
    assign o_segment_two   = r_out_seg2;
    assign o_timing_word   = r_out_word;

    // ---------------- assertions ----------------
    a_div_done_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider finished outside a search");

    a_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_prescaler != '0 && o_achieved_rate != '0
            && o_segment_one >= o_segment_two && o_segment_two >= 4'd2))
        else $error("found result with bad prescaler or segments");

    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_prescaler == '0 && o_achieved_rate == '0
            && o_segment_one == '0 && o_segment_two == '0))
        else $error("failed result carries nonzero fields");

    a_timing_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_timing) |-> $past(w_load))
        else $error("timing word changed outside a result load");

    a_load_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_timing_word) && $stable(o_found))
        else $error("stalled result overwritten");

endmodule

### sim/can_bit_timing_search_core_tb.sv
// Self-checking testbench for the CAN bit timing search core.
module can_bit_timing_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbts_pkg::*;

    // Every item gives one result word. A search that never hits walks all
    // 1023 prescalers with no word moving on either channel, so the watchdog
    // limit sits above the length of such a search.
    localparam int QUIET_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 4000;   // long receiver stall, fills the block
    localparam int DRAIN_PAD       = 64;     // settle time after the last result
    localparam int SEG2_CAP        = 8;
    localparam logic [W_RATE-1:0] RATE_MAX     = '1;
    localparam logic [W_ADDR-1:0] REG_UNMAPPED = 3'd4;  // index 1, not mapped

    typedef struct packed {
        logic [W_RATE-1:0] rate;
        logic              apply;
    } t_rate_req;

    typedef struct packed {
        logic              found;
        logic [W_RATE-1:0] achieved_rate;
        logic [W_PSC-1:0]  prescaler;
        logic [W_SEG-1:0]  segment_one;
        logic [W_SEG-1:0]  segment_two;
        logic [W_WORD-1:0] timing_word;
    } t_timing_result;

    // DUT ports; every input is known from time zero
    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_stall;
    logic [W_RATE-1:0] i_requested_rate = '0;
    logic              i_apply_setting  = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall      = 1'b0;
    logic              o_found;
    logic [W_RATE-1:0] o_achieved_rate;
    logic [W_PSC-1:0]  o_prescaler;
    logic [W_SEG-1:0]  o_segment_one;
    logic [W_SEG-1:0]  o_segment_two;
    logic [W_WORD-1:0] o_timing_word;
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [W_ADDR-1:0] paddr            = '0;
    logic [31:0]       pwdata           = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Shadow state of the block: clock register and stored timing word
    logic [W_CLK-1:0]  shadow_clock_hz    = CLOCK_RESET;
    logic [W_WORD-1:0] shadow_timing_word = '0;

    t_rate_req      rate_requests[$];     // words waiting to be offered
    t_timing_result expected_timings[$];  // predictions in acceptance order

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int hold_requests    = 0;   // bumped by stimulus, one long stall per bump
    int hold_served      = 0;   // owned by the result monitor
    int hold_left        = 0;
    int near_miss_budget = 4;   // near-miss rates usually fail the full search
    int mismatches       = 0;
    int quiet_cycles     = 0;

    can_bit_timing_search_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_requested_rate (i_requested_rate),
        .i_apply_setting  (i_apply_setting),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_achieved_rate  (o_achieved_rate),
        .o_prescaler      (o_prescaler),
        .o_segment_one    (o_segment_one),
        .o_segment_two    (o_segment_two),
        .o_timing_word    (o_timing_word),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #4 i_clk = ~i_clk;

    // Expected result of one search: first prescaler whose integer quanta
    // count lands in 5..16 and divides back to the rate exactly.
    function automatic t_timing_result search_timing(
        input logic [W_CLK-1:0]  clock_hz,
        input logic [W_RATE-1:0] rate,
        input logic              apply,
        input logic [W_WORD-1:0] word
    );
        int unsigned    scaled;
        int unsigned    q;
        int unsigned    quanta;
        int unsigned    p;
        int unsigned    seg1;
        int unsigned    seg2;
        logic           hit;
        t_timing_result r;
        hit    = 1'b0;
        quanta = 0;
        p      = 1;
        // zero rate: no division at all, straight to the failed result
        if (rate != '0) begin
            while (!hit && p <= MAX_PRESCALER) begin
                scaled = clock_hz / p;
                q      = scaled / rate;
                if (q >= MIN_QUANTA && q <= MAX_QUANTA && scaled / q == rate) begin
                    hit    = 1'b1;
                    quanta = q;
                end else begin
                    p++;
                end
            end
        end
        r             = '0;
        r.timing_word = word;
        if (hit) begin
            // one sync quantum; seg1 takes the odd quantum, seg2 capped
            seg2 = (quanta - 1) / 2;
            seg1 = quanta - 1 - seg2;
            if (seg2 > SEG2_CAP) begin
                seg1 += seg2 - SEG2_CAP;
                seg2  = SEG2_CAP;
            end
            r.found         = 1'b1;
            r.achieved_rate = rate;
            r.prescaler     = W_PSC'(p);
            r.segment_one   = W_SEG'(seg1);
            r.segment_two   = W_SEG'(seg2);
            // only a hit touches the stored word; bits outside the fields stay
            if (apply) begin
                r.timing_word = (word & ~(BRP_MASK | SEG_MASK))
                              | ((p - 1) & BRP_MASK)
                              | (((seg1 - 1) & 32'hf) << SEG1_SHIFT)
                              | (((seg2 - 1) & 32'h7) << SEG2_SHIFT);
            end
        end
        return r;
    endfunction

    // Random request: mostly rates built from a small prescaler and a legal
    // quanta count, so the search ends early; some zero and near-miss noise.
    function automatic t_rate_req make_rate_req();
        int unsigned p;
        int unsigned q;
        int unsigned r;
        int unsigned pick;
        t_rate_req   req;
        pick = $urandom_range(99, 0);
        do begin
            p = $urandom_range(24, 1);
            q = $urandom_range(16, 5);
            r = (shadow_clock_hz / p) / q;
        end while (r == 0 || r >= RATE_MAX);
        if (pick < 5) begin
            r = 0;
        end else if (pick < 12 && near_miss_budget > 0) begin
            near_miss_budget--;
            r = r + 1;
        end
        req.rate  = W_RATE'(r);
        req.apply = 1'($urandom_range(1, 0));
        return req;
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Input driver: holds a word until taken, predicts at acceptance
    always @(posedge i_clk) begin : drive_rates
        t_timing_result res;
        t_rate_req      req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                res = search_timing(shadow_clock_hz, i_requested_rate,
                                    i_apply_setting, shadow_timing_word);
                shadow_timing_word = res.timing_word;
                expected_timings.push_back(res);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (rate_requests.size() != 0 &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    req = rate_requests.pop_front();
                    i_in_valid       <= 1'b1;
                    i_requested_rate <= req.rate;
                    i_apply_setting  <= req.apply;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each taken word, drives the receiver stall
    always @(posedge i_clk) begin : watch_results
        t_timing_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_timings.size() == 0) begin
                    $error("result word with no prediction pending");
                    mismatches++;
                end else begin
                    want = expected_timings.pop_front();
                    check_field("found", 32'(want.found), 32'(o_found));
                    check_field("achieved_rate", 32'(want.achieved_rate),
                                32'(o_achieved_rate));
                    check_field("prescaler", 32'(want.prescaler), 32'(o_prescaler));
                    check_field("segment_one", 32'(want.segment_one),
                                32'(o_segment_one));
                    check_field("segment_two", 32'(want.segment_two),
                                32'(o_segment_two));
                    check_field("timing_word", want.timing_word, o_timing_word);
                end
            end
            // long hold-off counted here; sender keeps offering meanwhile
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_requests != hold_served) begin
                hold_served++;
                hold_left = HOLD_OFF_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles where neither channel moves a word
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no word moved for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic apb_write(input logic [W_ADDR-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // unmapped addresses are dropped by the block
        if (addr == REG_CLOCK) begin
            shadow_clock_hz = data[W_CLK-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_CLOCK;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", 32'(shadow_clock_hz), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_rate(input logic [W_RATE-1:0] rate, input logic apply);
        t_rate_req req;
        req.rate  = rate;
        req.apply = apply;
        rate_requests.push_back(req);
    endtask

    task automatic queue_random(input int count);
        repeat (count) rate_requests.push_back(make_rate_req());
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Block is idle once nothing is queued, offered or outstanding
    task automatic wait_drained();
        while (rate_requests.size() != 0 || i_in_valid ||
               expected_timings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb_read_check();                  // reset value of the clock register

        // Reset clock (36 MHz), no idling: directed edges
        @(negedge i_clk);
        set_idling(0, 0);
        queue_rate(20'd1000000, 1'b1);
        queue_rate(20'd1000000, 1'b0);
        queue_rate(20'd0, 1'b1);           // zero rate, no division
        queue_rate(RATE_MAX, 1'b1);        // no fit: word must stay as is
        queue_rate(20'd500000, 1'b1);
        queue_rate(20'd125000, 1'b1);
        wait_drained();

        // Lowest clock in range; sender mostly idle
        apb_write(REG_UNMAPPED, 32'd5);
        apb_read_check();
        apb_write(REG_CLOCK, 32'd1000000);
        apb_read_check();
        @(negedge i_clk);
        set_idling(81, 0);
        queue_rate(20'd200000, 1'b1);      // P = 1, five quanta
        queue_rate(20'd62500, 1'b0);       // P = 1, sixteen quanta
        queue_random(22);
        wait_drained();

        // Highest clock in range; receiver mostly stalling plus one long hold
        apb_write(REG_CLOCK, 32'd100000000);
        apb_read_check();
        @(negedge i_clk);
        set_idling(0, 81);
        hold_requests++;
        queue_rate(20'd1000000, 1'b1);
        queue_random(22);
        wait_drained();

        // Full 27-bit value, above range; both sides idle now and then
        apb_write(REG_CLOCK, 32'hffff_ffff);
        apb_read_check();
        @(negedge i_clk);
        set_idling(24, 24);
        queue_random(11);
        wait_drained();                    // sender waits out every result
        queue_random(11);
        wait_drained();

        // Zero clock: nothing can fit
        apb_write(REG_CLOCK, 32'd0);
        @(negedge i_clk);
        set_idling(0, 0);
        queue_rate(20'd1, 1'b1);
        wait_drained();

        // Tiny clock where the smallest rates still fit at P = 1
        apb_write(REG_CLOCK, 32'd10);
        @(negedge i_clk);
        queue_rate(20'd1, 1'b1);
        queue_rate(20'd2, 1'b0);
        wait_drained();

        // Back to 36 MHz, no idling
        apb_write(REG_CLOCK, 32'(CLOCK_RESET));
        apb_read_check();
        @(negedge i_clk);
        queue_random(22);
        wait_drained();

        repeat (DRAIN_PAD) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### can_bit_timing_search_core.f
rtl/cbts_pkg.sv
rtl/cbts_div.sv
rtl/can_bit_timing_search_core.sv
sim/can_bit_timing_search_core_tb.sv
